// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ptdu_pkg.sv =====
// ----------------------------------------------------------------------------
// ptdu_pkg
// shared types and constants of the per-track timestamp unwrapper
// ----------------------------------------------------------------------------
package ptdu_pkg;

    localparam int TRACKS_DEF = 16;
    localparam int TRK_W      = 8;   // wide enough for up to 256 tracks
    localparam int Q_DEPTH    = 2;

    localparam int TS_W    = 32;
    localparam int MAX_W   = 33;
    localparam int TSX_W   = 46;     // ts * 10000
    localparam int MAXX_W  = 47;     // max * 9999
    localparam int DELTA_W = 34;     // internal delta, may exceed 33 bits
    localparam int RUN_W   = 63;

    localparam logic [13:0] WRAP_TS_MUL  = 14'd10000;
    localparam logic [13:0] WRAP_MAX_MUL = 14'd9999;

    localparam logic [MAX_W-1:0]  MAX_TS_RST = 33'h1_0000_0000;
    localparam logic [MAXX_W-1:0] MAX_X_RST  =
        MAXX_W'(MAX_TS_RST) * MAXX_W'(WRAP_MAX_MUL);

    typedef enum logic [2:0] {
        EV_FIRST   = 3'd0,
        EV_NORMAL  = 3'd1,
        EV_WRAPPED = 3'd2,
        EV_CHANGED = 3'd3,
        EV_CLEARED = 3'd4
    } t_event_kind;

    // reduced and scaled transaction between front and back
    typedef struct packed {
        logic             clr;
        logic [TRK_W-1:0] trk;
        logic [TS_W-1:0]  ts;
        logic [TSX_W-1:0] ts_x;
    } t_item;

endpackage

// ===== rtl/core/ptdu_front.sv =====
// ----------------------------------------------------------------------------
// ptdu_front
// accepts input transactions, reduces the track index and scales the timestamp
// ----------------------------------------------------------------------------
module ptdu_front
    import ptdu_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [3:0]  i_track_index,
    input  logic [31:0] i_source_timestamp,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_q_full
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  w_accept;

    assign o_stall  = r_valid && i_q_full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_valid && !i_q_full;
    assign o_item   = r_item;

    always_comb begin
        n_item.clr  = i_func;
        n_item.trk  = '0;
        n_item.ts   = i_source_timestamp;
        n_item.ts_x = TSX_W'(i_source_timestamp) * TSX_W'(WRAP_TS_MUL);
        // track index modulo track count, as a small constant table
        for (int k = 0; k < 16; k++) begin
            if (i_track_index == 4'(k)) begin
                n_item.trk = TRK_W'(k % TRACKS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/core/ptdu_fifo.sv =====
// ----------------------------------------------------------------------------
// ptdu_fifo
// short queue decoupling the front and back parts
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptdu_fifo
    import ptdu_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `ASSERT_IMP(a_no_overflow, i_push, !o_full)
    `ASSERT_IMP(a_no_underflow, i_pop, o_valid)
    `ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

// ===== rtl/core/ptdu_back.sv =====
// ----------------------------------------------------------------------------
// ptdu_back
// per-track table update, delta and saturating accumulate, output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptdu_back
    import ptdu_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [MAX_W-1:0]    i_max_ts,
    input  logic [MAXX_W-1:0]   i_max_x,
    input  logic                i_q_valid,
    input  t_item               i_item,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [RUN_W-1:0]    o_adjusted_timestamp,
    output logic [MAX_W-1:0]    o_applied_delta,
    output logic [2:0]          o_event_kind
);

    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    logic [TRACKS-1:0] r_seen;
    logic [TS_W-1:0]   r_last   [TRACKS];
    logic [TSX_W-1:0]  r_last_x [TRACKS];
    logic [RUN_W-1:0]  r_run    [TRACKS];

    logic              r_out_valid;
    logic [RUN_W-1:0]  r_adj;
    logic [MAX_W-1:0]  r_delta;
    t_event_kind       r_kind;

    logic [TW-1:0]      w_idx;
    logic [TS_W-1:0]    w_last;
    logic [DELTA_W-1:0] w_pos;
    logic [DELTA_W-1:0] w_delta;
    logic [RUN_W:0]     w_sum;
    logic [RUN_W-1:0]   w_run_nx;
    t_event_kind        w_kind;

    assign o_pop = i_q_valid && (!r_out_valid || !i_stall);
    assign w_idx  = i_item.trk[TW-1:0];
    assign w_last = r_last[w_idx];
    assign w_pos  = DELTA_W'(i_max_ts) + DELTA_W'(i_item.ts);

    always_comb begin
        w_delta = '0;
        if (i_item.clr) begin
            w_kind = EV_CLEARED;
        end else if (!r_seen[w_idx]) begin
            w_kind = EV_FIRST;
        end else if (i_item.ts >= w_last) begin
            w_kind  = EV_NORMAL;
            w_delta = DELTA_W'(i_item.ts) - DELTA_W'(w_last);
        end else if (MAXX_W'(r_last_x[w_idx]) > i_max_x) begin
            w_kind = EV_WRAPPED;
            // negative wrap delta only with an out-of-range modulus
            if (w_pos > DELTA_W'(w_last)) begin
                w_delta = w_pos - DELTA_W'(w_last);
            end
        end else begin
            w_kind = EV_CHANGED;
        end
    end

    assign w_sum    = (RUN_W + 1)'(r_run[w_idx]) + (RUN_W + 1)'(w_delta);
    assign w_run_nx = w_sum[RUN_W] ? {RUN_W{1'b1}} : w_sum[RUN_W-1:0];

    // seen flags and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            for (int t = 0; t < TRACKS; t++) begin
                r_run[t] <= '0;
            end
        end else if (o_pop) begin
            if (i_item.clr) begin
                r_seen <= '0;
            end else begin
                r_seen[w_idx] <= 1'b1;
                r_run[w_idx]  <= w_run_nx;
            end
        end
    end

    // last timestamp store, read only while seen
    always_ff @(posedge i_clk) begin
        if (o_pop && !i_item.clr) begin
            r_last[w_idx]   <= i_item.ts;
            r_last_x[w_idx] <= i_item.ts_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_adj   <= i_item.clr ? '0 : w_run_nx;
            r_delta <= w_delta[MAX_W-1:0];
            r_kind  <= w_kind;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_adjusted_timestamp = r_adj;
    assign o_applied_delta      = r_delta;
    assign o_event_kind         = r_kind;

    `ASSERT_IMP(a_clear_zero, r_out_valid && r_kind == EV_CLEARED, r_adj == '0 && r_delta == '0)
    `ASSERT_IMP(a_first_zero, r_out_valid && r_kind == EV_FIRST, r_delta == '0)
    `ASSERT_NEXT(a_clear_drops, o_pop && i_item.clr, r_seen == '0)

endmodule

// ===== rtl/core/per_track_timestamp_delta_unwrapper_top.sv =====
// ----------------------------------------------------------------------------
// per_track_timestamp_delta_unwrapper_top
// path: the front register, the queue, then the back output register
// throughput: one transaction per cycle while the result channel is not stalled
// reset: synchronous active-low; clears seen flags, running sums, queue, and
// sets the modulus to 2^32; no clearing pass, the block is ready right away
// ----------------------------------------------------------------------------
module per_track_timestamp_delta_unwrapper_top
    import ptdu_pkg::*;
#(
    parameter int TRACKS = TRACKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: modulus of the source timestamp
    input  logic        i_cfg_we,
    input  logic [32:0] i_cfg_wdata,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [3:0]  i_track_index,
    input  logic [31:0] i_source_timestamp,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [62:0] o_adjusted_timestamp,
    output logic [32:0] o_applied_delta,
    output logic [2:0]  o_event_kind
);

    // modulus and its 99.99% comparison product, both held in registers so
    // the wrap test per transaction is a plain 47-bit compare
    logic [MAX_W-1:0]  r_max_ts;
    logic [MAXX_W-1:0] r_max_x;

    // front to queue
    logic  w_push;
    t_item w_push_item;
    logic  w_q_full;

    // queue to back
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_ts <= MAX_TS_RST;
            r_max_x  <= MAX_X_RST;
        end else if (i_cfg_we) begin
            r_max_ts <= i_cfg_wdata;
            r_max_x  <= MAXX_W'(i_cfg_wdata) * MAXX_W'(WRAP_MAX_MUL);
        end
    end

    // front: takes the transaction, reduces the track, scales ts by 10000
    ptdu_front #(
        .TRACKS (TRACKS)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_func             (i_func),
        .i_track_index      (i_track_index),
        .i_source_timestamp (i_source_timestamp),
        .o_push             (w_push),
        .o_item             (w_push_item),
        .i_q_full           (w_q_full)
    );

    // short queue so a stalled result does not hold up the front
    ptdu_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    // back: per-track read-modify-write and the result register
    ptdu_back #(
        .TRACKS (TRACKS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_max_ts             (r_max_ts),
        .i_max_x              (r_max_x),
        .i_q_valid            (w_q_valid),
        .i_item               (w_q_item),
        .o_pop                (w_pop),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_adjusted_timestamp (o_adjusted_timestamp),
        .o_applied_delta      (o_applied_delta),
        .o_event_kind         (o_event_kind)
    );

endmodule
